// File: hdl/trv_pkg.sv
// ----------------------------------------------------------------------------
// trv_pkg
// Shared types and codes for the timestamp range validator.
// ----------------------------------------------------------------------------
`default_nettype none

package trv_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic [3:0] CMD_INSERT  = 4'd0;
    localparam logic [3:0] CMD_RELEASE = 4'd1;
    localparam logic [3:0] CMD_READ    = 4'd2;
    localparam logic [3:0] CMD_SET_LO  = 4'd3;
    localparam logic [3:0] CMD_SET_UP  = 4'd4;
    localparam logic [3:0] CMD_SET_ST  = 4'd5;
    localparam logic [3:0] CMD_OPEN    = 4'd6;
    localparam logic [3:0] CMD_CHK_W   = 4'd7;
    localparam logic [3:0] CMD_CHK_R   = 4'd8;
    localparam logic [3:0] CMD_CHK_WW  = 4'd9;
    localparam logic [3:0] CMD_END     = 4'd10;
    localparam logic [3:0] CMD_BOUND   = 4'd11;

    localparam logic [1:0] ST_RUNNING   = 2'd0;
    localparam logic [1:0] ST_VALIDATED = 2'd1;
    localparam logic [1:0] ST_COMMITTED = 2'd2;
    localparam logic [1:0] ST_ABORTED   = 2'd3;

    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_ABORT   = 2'd1;
    localparam logic [1:0] RES_MISSING = 2'd2;
    localparam logic [1:0] RES_FULL    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input transfer
        logic search;   // run associative search
        logic execute;  // update table and form result
    } trv_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
    } trv_stat_t;

endpackage

`default_nettype wire

// File: hdl/timestamp_range_validator_core.sv
// ----------------------------------------------------------------------------
// timestamp_range_validator_core
// Key-matched transaction table with timestamp range validation.
// ----------------------------------------------------------------------------
// Each command goes from input transfer to result in order: a capture, an
// associative search over all 64 entries (registered match and free-slot
// indexes and the matched entry's fields), then an update of the entry or the
// working bounds that also loads the output register. A new command
// is accepted once the previous one has finished executing; a waiting result
// does not block the capture and search of the next one.
`default_nettype none

module timestamp_range_validator_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // command[3:0], key[67:4], value[131:68], read_timestamp[195:132],
    // new_state[197:196], zero fill to 200
    input  wire logic [199:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // status[1:0], lower_bound[65:2], upper_bound[129:66],
    // entry_state_out[131:130], commit_ts[195:132], zero fill to 200
    output logic [199:0]       m_axis_tdata
);

    trv_pkg::trv_cmd_t  cmd;
    trv_pkg::trv_stat_t stat;

    logic [1:0]  status, est;
    logic [63:0] lo, up, ct;

    trv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    trv_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_command      (s_axis_tdata[3:0]),
        .in_key          (s_axis_tdata[67:4]),
        .in_value        (s_axis_tdata[131:68]),
        .in_rts          (s_axis_tdata[195:132]),
        .in_state        (s_axis_tdata[197:196]),
        .status          (status),
        .lower_bound     (lo),
        .upper_bound     (up),
        .entry_state_out (est),
        .commit_ts       (ct)
    );

    assign m_axis_tdata = {4'd0, ct, est, up, lo, status};

    // a result is shown only after a command was accepted
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.execute))
        else $error("result without command");

    // no new command while one is in flight
    a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted during search");

    // commit time nonzero only with ok status
    a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[195:132] != 64'd0) |->
        (m_axis_tdata[1:0] == trv_pkg::RES_OK))
        else $error("commit time with bad status");

endmodule

`default_nettype wire

// File: hdl/trv_ctrl.sv
// ----------------------------------------------------------------------------
// trv_ctrl
// Sequencer: accept, search, execute, present result.
// ----------------------------------------------------------------------------
`default_nettype none

module trv_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output trv_pkg::trv_cmd_t      cmd,
    input  wire trv_pkg::trv_stat_t stat
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    // result may wait in output register while next item is searched
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ovalid_reg;
    assign cmd.load    = in_valid && in_ready;
    assign cmd.search  = (state_reg == S_SEARCH);
    assign cmd.execute = (state_reg == S_EXEC) && (!ovalid_reg || out_ready);

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_SEARCH;
            S_SEARCH:
                state_next = S_EXEC;
            S_EXEC:
                if (cmd.execute && stat.done)
                begin
                    state_next  = S_IDLE;
                    ovalid_next = 1'b1;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/trv_dp.sv
// ----------------------------------------------------------------------------
// trv_dp
// Entry table, associative search, bound arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trv_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire trv_pkg::trv_cmd_t   cmd,
    output trv_pkg::trv_stat_t       stat,
    input  wire logic [3:0]          in_command,
    input  wire logic [63:0]         in_key,
    input  wire logic [63:0]         in_value,
    input  wire logic [63:0]         in_rts,
    input  wire logic [1:0]          in_state,
    output logic [1:0]               status,
    output logic [63:0]              lower_bound,
    output logic [63:0]              upper_bound,
    output logic [1:0]               entry_state_out,
    output logic [63:0]              commit_ts
);

    localparam int N  = trv_pkg::TABLE_ENTRIES;
    localparam int IW = trv_pkg::IDX_W;
    localparam logic [63:0] ONES = '1;

    // entry table
    logic [N-1:0]  valid_reg;
    logic [63:0]   key_mem   [N];
    logic [63:0]   lower_mem [N];
    logic [63:0]   upper_mem [N];
    logic [1:0]    state_mem [N];

    logic [63:0] work_key_reg, work_lower_reg, work_upper_reg;

    // captured command
    logic [3:0]  c_cmd_reg;
    logic [63:0] c_key_reg, c_val_reg, c_rts_reg;
    logic [1:0]  c_ns_reg;

    // search results
    logic          hit_reg, free_any_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    logic [63:0]   rd_lo_reg, rd_up_reg;
    logic [1:0]    rd_st_reg;

    logic [1:0]  status_reg;
    logic [63:0] lo_reg, up_reg, ct_reg;
    logic [1:0]  est_reg;

    assign stat.done       = cmd.execute;
    assign status          = status_reg;
    assign lower_bound     = lo_reg;
    assign upper_bound     = up_reg;
    assign entry_state_out = est_reg;
    assign commit_ts       = ct_reg;

    // search key: end uses the working transaction
    logic [63:0] skey;
    assign skey = (c_cmd_reg == trv_pkg::CMD_END) ? work_key_reg : c_key_reg;

    logic [N-1:0] match;
    always_comb
    begin
        for (int k = 0; k < N; k++)
            match[k] = valid_reg[k] && (key_mem[k] == skey);
    end

    // priority encoders for first match and first free slot
    logic          m_any, f_any;
    logic [IW-1:0] m_idx, f_idx;
    always_comb
    begin
        m_any = 1'b0;
        f_any = 1'b0;
        m_idx = '0;
        f_idx = '0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                m_any = 1'b1;
                m_idx = IW'(k);
            end
            if (!valid_reg[k])
            begin
                f_any = 1'b1;
                f_idx = IW'(k);
            end
        end
    end

    // capture, then registered search result and entry read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_cmd_reg <= in_command;
            c_key_reg <= in_key;
            c_val_reg <= in_value;
            c_rts_reg <= in_rts;
            c_ns_reg  <= in_state;
        end
        if (cmd.search)
        begin
            hit_reg      <= m_any;
            hit_idx_reg  <= m_idx;
            free_any_reg <= f_any;
            free_idx_reg <= f_idx;
            rd_lo_reg    <= lower_mem[m_idx];
            rd_up_reg    <= upper_mem[m_idx];
            rd_st_reg    <= state_mem[m_idx];
        end
    end

    // entry fields seen by execute
    logic [63:0] e_lo, e_up;
    logic [1:0]  e_st;
    assign e_lo = hit_reg ? rd_lo_reg : 64'd0;
    assign e_up = hit_reg ? rd_up_reg : ONES;
    assign e_st = hit_reg ? rd_st_reg : trv_pkg::ST_ABORTED;

    logic settled;
    assign settled = (e_st == trv_pkg::ST_VALIDATED) || (e_st == trv_pkg::ST_COMMITTED);

    // open: raise lower past write and read timestamps
    logic [63:0] op1, op2;
    always_comb
    begin
        op1 = e_lo;
        if (op1 <= c_val_reg)
            op1 = (c_val_reg == ONES) ? ONES : c_val_reg + 64'd1;
        op2 = op1;
        if (op2 <= c_rts_reg)
            op2 = (c_rts_reg == ONES) ? ONES : c_rts_reg + 64'd1;
    end

    // execute: next values of table, working registers and result
    logic        wr_en, wr_new, wr_clr;
    logic [63:0] n_lo, n_up, n_wl, n_wu, n_wk;
    logic [1:0]  n_st, r_status, r_est;
    logic [63:0] r_lo, r_up, r_ct;
    logic        abort_w;
    always_comb
    begin
        wr_en    = 1'b0;
        wr_new   = 1'b0;
        wr_clr   = 1'b0;
        n_lo     = e_lo;
        n_up     = e_up;
        n_st     = e_st;
        n_wk     = work_key_reg;
        n_wl     = work_lower_reg;
        n_wu     = work_upper_reg;
        r_status = hit_reg ? trv_pkg::RES_OK : trv_pkg::RES_MISSING;
        r_lo     = e_lo;
        r_up     = e_up;
        r_est    = e_st;
        r_ct     = 64'd0;
        abort_w  = (work_lower_reg >= work_upper_reg);
        case (c_cmd_reg)
            trv_pkg::CMD_INSERT:
            begin
                r_status = trv_pkg::RES_OK;
                if (!hit_reg)
                begin
                    if (!free_any_reg)
                        r_status = trv_pkg::RES_FULL;
                    else
                    begin
                        wr_new = 1'b1;
                        r_lo   = 64'd0;
                        r_up   = ONES;
                        r_est  = trv_pkg::ST_RUNNING;
                    end
                end
            end
            trv_pkg::CMD_RELEASE:
                wr_clr = hit_reg;
            trv_pkg::CMD_READ:
                ;
            trv_pkg::CMD_SET_LO:
            begin
                wr_en = hit_reg;
                n_lo  = c_val_reg;
                if (hit_reg)
                    r_lo = c_val_reg;
            end
            trv_pkg::CMD_SET_UP:
            begin
                wr_en = hit_reg;
                n_up  = c_val_reg;
                if (hit_reg)
                    r_up = c_val_reg;
            end
            trv_pkg::CMD_SET_ST:
            begin
                wr_en = hit_reg;
                n_st  = c_ns_reg;
                if (hit_reg)
                    r_est = c_ns_reg;
            end
            trv_pkg::CMD_OPEN:
            begin
                n_wk = c_key_reg;
                n_wl = op2;
                n_wu = e_up;
                r_lo = op2;
                r_up = e_up;
            end
            trv_pkg::CMD_CHK_W:
            begin
                if (hit_reg && settled && work_upper_reg >= e_lo)
                    n_wu = (e_lo == 64'd0) ? 64'd0 : e_lo - 64'd1;
                r_lo = n_wl;
                r_up = n_wu;
            end
            trv_pkg::CMD_CHK_R, trv_pkg::CMD_CHK_WW:
            begin
                if (hit_reg && settled && work_lower_reg <= e_up)
                    n_wl = (e_up == ONES) ? ONES : e_up + 64'd1;
                r_lo = n_wl;
                r_up = n_wu;
            end
            trv_pkg::CMD_END:
            begin
                wr_en = hit_reg;
                n_lo  = work_lower_reg;
                n_up  = work_upper_reg;
                n_st  = abort_w ? trv_pkg::ST_ABORTED : trv_pkg::ST_VALIDATED;
                if (hit_reg)
                begin
                    r_est    = n_st;
                    r_status = abort_w ? trv_pkg::RES_ABORT : trv_pkg::RES_OK;
                end
                r_lo = work_lower_reg;
                r_up = work_upper_reg;
            end
            trv_pkg::CMD_BOUND:
            begin
                wr_en = hit_reg;
                if (e_lo >= e_up)
                begin
                    n_st = trv_pkg::ST_ABORTED;
                    if (hit_reg)
                        r_status = trv_pkg::RES_ABORT;
                end
                else
                begin
                    n_st = trv_pkg::ST_COMMITTED;
                    if (hit_reg)
                        r_ct = e_lo;
                end
                if (hit_reg)
                    r_est = n_st;
            end
            default:
            begin
                r_status = trv_pkg::RES_OK;
                r_lo     = 64'd0;
                r_up     = 64'd0;
                r_est    = 2'd0;
            end
        endcase
    end

    // table write port
    logic [IW-1:0] w_idx;
    assign w_idx = wr_new ? free_idx_reg : hit_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            if (wr_new)
            begin
                key_mem[w_idx]   <= c_key_reg;
                lower_mem[w_idx] <= 64'd0;
                upper_mem[w_idx] <= ONES;
                state_mem[w_idx] <= trv_pkg::ST_RUNNING;
            end
            else if (wr_en)
            begin
                lower_mem[w_idx] <= n_lo;
                upper_mem[w_idx] <= n_up;
                state_mem[w_idx] <= n_st;
            end
            status_reg <= r_status;
            lo_reg     <= r_lo;
            up_reg     <= r_up;
            est_reg    <= r_est;
            ct_reg     <= r_ct;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            work_key_reg   <= 64'd0;
            work_lower_reg <= 64'd0;
            work_upper_reg <= ONES;
        end
        else if (cmd.execute)
        begin
            if (wr_new)
                valid_reg[w_idx] <= 1'b1;
            else if (wr_clr)
                valid_reg[w_idx] <= 1'b0;
            work_key_reg   <= n_wk;
            work_lower_reg <= n_wl;
            work_upper_reg <= n_wu;
        end
    end

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timestamp range validator: a directed command
// table followed by transaction-shaped random traffic, every result checked
// against a behavioral model of the entry table and the working bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam int          IDLE_LIMIT = 4000;
    localparam int          RANDOM_ITEMS = 1500;

    typedef struct packed {
        logic [1:0]  new_state;
        logic [63:0] rts;
        logic [63:0] value;
        logic [63:0] key;
        logic [3:0]  cmd;
    } command_t;

    typedef struct packed {
        logic [63:0] commit_ts;
        logic [1:0]  entry_state;
        logic [63:0] upper;
        logic [63:0] lower;
        logic [1:0]  status;
    } result_t;

    // directed row: command plus optional typed-in expectation
    typedef struct {
        command_t    c;
        bit          fixed;
        result_t     r;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [199:0] m_axis_tdata;

    // model state
    bit          tbl_valid [trv_pkg::TABLE_ENTRIES];
    logic [63:0] tbl_key   [trv_pkg::TABLE_ENTRIES];
    logic [63:0] tbl_lower [trv_pkg::TABLE_ENTRIES];
    logic [63:0] tbl_upper [trv_pkg::TABLE_ENTRIES];
    logic [1:0]  tbl_state [trv_pkg::TABLE_ENTRIES];
    logic [63:0] cur_key;
    logic [63:0] cur_lower;
    logic [63:0] cur_upper;

    result_t     pending_results[$];
    row_t        directed[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;
    bit          long_hold = 1'b0;
    logic [63:0] key_pool[8];

    timestamp_range_validator_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic int find_slot(logic [63:0] k);
        for (int n = 0; n < trv_pkg::TABLE_ENTRIES; n++)
            if (tbl_valid[n] && tbl_key[n] == k)
                return n;
        return -1;
    endfunction

    function automatic logic [63:0] sat_up(logic [63:0] v);
        return (v == ALL_ONES) ? v : v + 64'd1;
    endfunction

    function automatic logic [63:0] sat_down(logic [63:0] v);
        return (v == 64'd0) ? v : v - 64'd1;
    endfunction

    function automatic void fill_entry(ref result_t r, input int n);
        if (n < 0)
        begin
            r.lower = '0;
            r.upper = ALL_ONES;
            r.entry_state = trv_pkg::ST_ABORTED;
        end
        else
        begin
            r.lower = tbl_lower[n];
            r.upper = tbl_upper[n];
            r.entry_state = tbl_state[n];
        end
    endfunction

    // applies one command to the table model and returns its result
    function automatic result_t validate_command(command_t c);
        result_t r;
        int      n;
        int      f;
        r = '0;
        n = find_slot(c.key);
        case (c.cmd)
            trv_pkg::CMD_INSERT:
            begin
                if (n < 0)
                begin
                    f = -1;
                    for (int s = trv_pkg::TABLE_ENTRIES - 1; s >= 0; s--)
                        if (!tbl_valid[s])
                            f = s;
                    if (f < 0)
                        r.status = trv_pkg::RES_FULL;
                    else
                    begin
                        tbl_valid[f] = 1'b1;
                        tbl_key[f] = c.key;
                        tbl_lower[f] = '0;
                        tbl_upper[f] = ALL_ONES;
                        tbl_state[f] = trv_pkg::ST_RUNNING;
                    end
                    n = f;
                end
                fill_entry(r, n);
            end
            trv_pkg::CMD_RELEASE, trv_pkg::CMD_READ, trv_pkg::CMD_SET_LO,
            trv_pkg::CMD_SET_UP, trv_pkg::CMD_SET_ST:
            begin
                if (n < 0)
                    r.status = trv_pkg::RES_MISSING;
                else if (c.cmd == trv_pkg::CMD_RELEASE)
                    tbl_valid[n] = 1'b0;
                else if (c.cmd == trv_pkg::CMD_SET_LO)
                    tbl_lower[n] = c.value;
                else if (c.cmd == trv_pkg::CMD_SET_UP)
                    tbl_upper[n] = c.value;
                else if (c.cmd == trv_pkg::CMD_SET_ST)
                    tbl_state[n] = c.new_state;
                fill_entry(r, n);
            end
            trv_pkg::CMD_OPEN:
            begin
                cur_key = c.key;
                cur_lower = (n < 0) ? '0 : tbl_lower[n];
                cur_upper = (n < 0) ? ALL_ONES : tbl_upper[n];
                if (cur_lower <= c.value)
                    cur_lower = sat_up(c.value);
                if (cur_lower <= c.rts)
                    cur_lower = sat_up(c.rts);
                if (n < 0)
                    r.status = trv_pkg::RES_MISSING;
                fill_entry(r, n);
                r.lower = cur_lower;
                r.upper = cur_upper;
            end
            trv_pkg::CMD_CHK_W, trv_pkg::CMD_CHK_R, trv_pkg::CMD_CHK_WW:
            begin
                if (n < 0)
                    r.status = trv_pkg::RES_MISSING;
                else if (tbl_state[n] == trv_pkg::ST_VALIDATED ||
                         tbl_state[n] == trv_pkg::ST_COMMITTED)
                begin
                    if (c.cmd == trv_pkg::CMD_CHK_W)
                    begin
                        if (cur_upper >= tbl_lower[n])
                            cur_upper = sat_down(tbl_lower[n]);
                    end
                    else if (cur_lower <= tbl_upper[n])
                        cur_lower = sat_up(tbl_upper[n]);
                end
                fill_entry(r, n);
                r.lower = cur_lower;
                r.upper = cur_upper;
            end
            trv_pkg::CMD_END:
            begin
                n = find_slot(cur_key);
                if (n < 0)
                    r.status = trv_pkg::RES_MISSING;
                else
                begin
                    if (cur_lower >= cur_upper)
                    begin
                        tbl_state[n] = trv_pkg::ST_ABORTED;
                        r.status = trv_pkg::RES_ABORT;
                    end
                    else
                        tbl_state[n] = trv_pkg::ST_VALIDATED;
                    tbl_lower[n] = cur_lower;
                    tbl_upper[n] = cur_upper;
                end
                fill_entry(r, n);
                r.lower = cur_lower;
                r.upper = cur_upper;
            end
            trv_pkg::CMD_BOUND:
            begin
                if (n < 0)
                    r.status = trv_pkg::RES_MISSING;
                else if (tbl_lower[n] >= tbl_upper[n])
                begin
                    tbl_state[n] = trv_pkg::ST_ABORTED;
                    r.status = trv_pkg::RES_ABORT;
                end
                else
                begin
                    tbl_state[n] = trv_pkg::ST_COMMITTED;
                    r.commit_ts = tbl_lower[n];
                end
                fill_entry(r, n);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // timestamp with a good share of edge values
    function automatic logic [63:0] rand_ts();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ALL_ONES - $urandom_range(0, 2);
            2: return rand64();
            default: return 64'($urandom_range(0, 200));
        endcase
    endfunction

    function automatic command_t make_cmd(logic [3:0] op, logic [63:0] k,
                                          logic [63:0] v = '0, logic [63:0] t = '0,
                                          logic [1:0] s = trv_pkg::ST_RUNNING);
        command_t c;
        c.cmd = op;
        c.key = k;
        c.value = v;
        c.rts = t;
        c.new_state = s;
        return c;
    endfunction

    function automatic result_t make_res(logic [1:0] st, logic [63:0] lo,
                                         logic [63:0] up, logic [1:0] es);
        result_t r;
        r = '0;
        r.status = st;
        r.lower = lo;
        r.upper = up;
        r.entry_state = es;
        return r;
    endfunction

    function automatic void add_row(command_t c, bit fx = 1'b0, result_t r = '0);
        row_t w;
        w.c = c;
        w.fixed = fx;
        w.r = r;
        directed.push_back(w);
    endfunction

    // sends one command once the sender's random gap has passed
    task automatic send_command(command_t c, bit fx, result_t fixed_res);
        result_t r;
        int      gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, c};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = validate_command(c);
        if (fx && r != fixed_res)
            report_mismatch("directed row vs model", r[63:0], fixed_res[63:0]);
        pending_results.push_back(fx ? fixed_res : r);
    endtask

    function automatic logic [63:0] pick_key();
        return ($urandom_range(0, 19) == 0) ? rand64() : key_pool[$urandom_range(0, 7)];
    endfunction

    // stimulus
    initial
    begin
        command_t c;
        logic [63:0] k;
        int          sent;
        for (int n = 0; n < trv_pkg::TABLE_ENTRIES; n++)
            tbl_valid[n] = 1'b0;
        cur_key = '0;
        cur_lower = '0;
        cur_upper = ALL_ONES;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(make_cmd(trv_pkg::CMD_READ, 64'd5), 1'b1,
                make_res(trv_pkg::RES_MISSING, '0, ALL_ONES, trv_pkg::ST_ABORTED));
        add_row(make_cmd(trv_pkg::CMD_END, 64'd0), 1'b1,
                make_res(trv_pkg::RES_MISSING, '0, ALL_ONES, trv_pkg::ST_ABORTED));
        add_row(make_cmd(trv_pkg::CMD_INSERT, ALL_ONES), 1'b1,
                make_res(trv_pkg::RES_OK, '0, ALL_ONES, trv_pkg::ST_RUNNING));
        add_row(make_cmd(trv_pkg::CMD_INSERT, ALL_ONES), 1'b1,
                make_res(trv_pkg::RES_OK, '0, ALL_ONES, trv_pkg::ST_RUNNING));
        add_row(make_cmd(trv_pkg::CMD_INSERT, 64'd0));
        add_row(make_cmd(trv_pkg::CMD_SET_LO, 64'd0, ALL_ONES));
        add_row(make_cmd(trv_pkg::CMD_SET_UP, 64'd0, 64'd0));
        add_row(make_cmd(trv_pkg::CMD_BOUND, 64'd0));
        add_row(make_cmd(trv_pkg::CMD_SET_LO, ALL_ONES, 64'd10));
        add_row(make_cmd(trv_pkg::CMD_SET_UP, ALL_ONES, 64'd50));
        add_row(make_cmd(trv_pkg::CMD_SET_ST, ALL_ONES, 64'hAAAA, ALL_ONES,
                         trv_pkg::ST_VALIDATED));
        add_row(make_cmd(trv_pkg::CMD_OPEN, 64'd77, ALL_ONES, ALL_ONES));
        add_row(make_cmd(trv_pkg::CMD_CHK_W, ALL_ONES));
        add_row(make_cmd(trv_pkg::CMD_CHK_R, ALL_ONES));
        add_row(make_cmd(trv_pkg::CMD_CHK_WW, 64'd0));
        add_row(make_cmd(trv_pkg::CMD_CHK_R, 64'd1234));
        add_row(make_cmd(trv_pkg::CMD_END, 64'd0));
        add_row(make_cmd(trv_pkg::CMD_INSERT, 64'd77));
        add_row(make_cmd(trv_pkg::CMD_OPEN, 64'd77, 64'd3, 64'd8));
        add_row(make_cmd(trv_pkg::CMD_END, 64'd0));
        add_row(make_cmd(trv_pkg::CMD_BOUND, 64'd77));
        add_row(make_cmd(trv_pkg::CMD_RELEASE, 64'd77));
        add_row(make_cmd(4'd12, 64'd77), 1'b1, '0);
        add_row(make_cmd(4'd15, ALL_ONES, ALL_ONES, ALL_ONES, trv_pkg::ST_ABORTED),
                1'b1, '0);
        foreach (directed[n])
            send_command(directed[n].c, directed[n].fixed, directed[n].r);

        // insert one key per table entry, so the last ones see it full, then release them
        for (int n = 0; n < trv_pkg::TABLE_ENTRIES; n++)
            send_command(make_cmd(trv_pkg::CMD_INSERT, 64'h1000 + n), 1'b0, '0);
        for (int n = 0; n < trv_pkg::TABLE_ENTRIES; n++)
            send_command(make_cmd(trv_pkg::CMD_RELEASE, 64'h1000 + n), 1'b0, '0);

        // random transactions over a small key pool
        for (int n = 0; n < 8; n++)
            key_pool[n] = (n == 0) ? ALL_ONES : rand64();
        long_hold = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // validation: insert, open, a few checks, end, maybe bound
                k = key_pool[$urandom_range(0, 7)];
                send_command(make_cmd(trv_pkg::CMD_INSERT, k), 1'b0, '0);
                send_command(make_cmd(trv_pkg::CMD_OPEN, k, rand_ts(), rand_ts()),
                             1'b0, '0);
                sent += 2;
                repeat ($urandom_range(0, 4))
                begin
                    c = make_cmd(4'(trv_pkg::CMD_CHK_W + $urandom_range(0, 2)),
                                 pick_key(), rand64(), rand64(), 2'($urandom));
                    send_command(c, 1'b0, '0);
                    sent++;
                end
                send_command(make_cmd(trv_pkg::CMD_END, rand64()), 1'b0, '0);
                sent++;
                if ($urandom_range(0, 1))
                begin
                    send_command(make_cmd(trv_pkg::CMD_BOUND, k), 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                // noise: any command on any field values
                c = make_cmd(4'($urandom_range(0, 15)), pick_key(), rand_ts(), rand_ts(),
                             2'($urandom));
                if (c.cmd == trv_pkg::CMD_SET_LO || c.cmd == trv_pkg::CMD_SET_UP)
                    c.value = rand_ts();
                send_command(c, 1'b0, '0);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off early in the random part
    initial
    begin
        int  wait_cycles;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold && !held)
            begin
                held = 1'b1;
                wait_cycles = 300;
            end
            else
            begin
                wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                if ($urandom_range(0, 2) == 0)
                    wait_cycles = 0;
            end
            if (wait_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // result check
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[195:0];
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", got[63:0], '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.lower !== want.lower)
                    report_mismatch("lower_bound", got.lower, want.lower);
                if (got.upper !== want.upper)
                    report_mismatch("upper_bound", got.upper, want.upper);
                if (got.entry_state !== want.entry_state)
                    report_mismatch("entry_state_out", 64'(got.entry_state),
                                    64'(want.entry_state));
                if (got.commit_ts !== want.commit_ts)
                    report_mismatch("commit_ts", got.commit_ts, want.commit_ts);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
